// File: rtl/core/block_buffer_cache_directory_macros.svh
// Assertion macros shared by the directory checkers.
// Needs clk and rst in the scope where a macro is used.
`ifndef BLOCK_BUFFER_CACHE_DIRECTORY_MACROS_SVH
`define BLOCK_BUFFER_CACHE_DIRECTORY_MACROS_SVH

// same-cycle implication
`define BBC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("directory check failed");

// next-cycle implication
`define BBC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("directory check failed");

`endif

// File: rtl/core/bbc_pkg.sv
// Shared constants and types of the buffer cache directory.
// No dependencies.
`timescale 1ns / 1ps
package bbc_pkg;
  localparam int NUM_SLOTS   = 64;
  localparam int DEVICE_BITS = 8;

  localparam int SLOT_AW = $clog2(NUM_SLOTS);
  localparam int LINK_W  = $clog2(NUM_SLOTS + 1);

  localparam int DEV_KEEP = (DEVICE_BITS > 8) ? 8 : DEVICE_BITS;
  localparam logic [7:0] DEV_MASK = 8'((9'd1 << DEV_KEEP) - 9'd1);

  localparam logic [LINK_W-1:0] EMPTY = LINK_W'(NUM_SLOTS);

  localparam logic OP_GET     = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_MISS     = 3'd1;
  localparam logic [2:0] ST_NOBUF    = 3'd2;
  localparam logic [2:0] ST_RELEASED = 3'd3;
  localparam logic [2:0] ST_UNREF    = 3'd4;

  typedef struct packed {
    logic [7:0]  dev;
    logic [31:0] blk;
    logic [7:0]  cnt;
  } meta_t;
endpackage

// File: rtl/core/bbc_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module bbc_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/block_buffer_cache_directory.sv
// Block buffer cache directory: get / release of tagged buffer slots, LRU free list.
// Uses bbc_pkg and bbc_ram.
//
// Usage:
//   Input channel (in_valid / in_stall): operation 0 is a get of device and
//   block_number, operation 1 a release of slot (modified marks it dirty).
//   One request is worked on at a time; in_stall is high while it runs.
//   Output channel (out_valid / out_stall): one result per request, held in
//   an output register, so a new request is taken while a result still waits.
//   Config channel (cfg_valid / cfg_ready): writes sectors_per_block.
// Steps from acceptance to result:
//   get: tag RAM scanned one slot per cycle in slot order, stops at the first
//   hit; a hit on a slot in the free list also unlinks it from the list. A
//   miss scans all slots, then takes a never-used slot or else reuses the least
//   recently released slot, unlinking it from the free list.
//   release: read, update, optional free-list push.
//   After each result the block returns to idle, where it takes the next request.
// Reset: all slots untagged, free list empty, sectors_per_block = 2.
//   No clearing pass; the slot flags and free-list pointers are reset registers.
// Stall: a finished result waits in the finish step until the output
//   register is free; the block then returns to idle and takes the next request.
`timescale 1ns / 1ps
module block_buffer_cache_directory (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [7:0]  device,
  input  logic [31:0] block_number,
  input  logic [5:0]  slot,
  input  logic        modified,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [5:0]  result_slot,
  output logic        read_request,
  output logic        write_request,
  output logic [7:0]  request_device,
  output logic [34:0] request_sector,
  output logic [7:0]  reference_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);
  import bbc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_HIT, S_MISS, S_UNL_RD, S_UNL_WR,
    S_REL_RD, S_REL_CK, S_PUSH0, S_PUSH1, S_FIN
  } state_t;

  state_t state;

  logic [3:0]          spb;
  logic [7:0]          op_dev;
  logic [31:0]         op_blk;
  logic                op_mod;
  logic [SLOT_AW-1:0]  s_reg;
  logic [LINK_W-1:0]   scan_idx;
  logic [SLOT_AW-1:0]  chk_idx;
  logic                chk_valid;
  logic [7:0]          cnt_reg;
  logic [NUM_SLOTS-1:0] slot_tagged;
  logic [NUM_SLOTS-1:0] on_free;
  logic [LINK_W-1:0]   head;
  logic [LINK_W-1:0]   tail;
  logic [LINK_W-1:0]   handed;

  logic [2:0]  res_status;
  logic [5:0]  res_slot;
  logic        res_rd;
  logic        res_wr;
  logic [7:0]  res_dev;
  logic [34:0] res_sec;
  logic [7:0]  res_cnt;

  // memories
  meta_t              meta_rd, meta_wd;
  logic               meta_we;
  logic [SLOT_AW-1:0] meta_waddr, meta_raddr;
  logic [LINK_W-1:0]  prev_rd, next_rd, prev_wd, next_wd;
  logic               prev_we, next_we;
  logic [SLOT_AW-1:0] prev_waddr, next_waddr;

  bbc_ram #(.WIDTH($bits(meta_t)), .DEPTH(NUM_SLOTS)) u_meta (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wd),
    .raddr(meta_raddr), .rdata(meta_rd)
  );
  bbc_ram #(.WIDTH(LINK_W), .DEPTH(NUM_SLOTS)) u_prev (
    .clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wd),
    .raddr(s_reg), .rdata(prev_rd)
  );
  bbc_ram #(.WIDTH(LINK_W), .DEPTH(NUM_SLOTS)) u_next (
    .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wd),
    .raddr(s_reg), .rdata(next_rd)
  );

  logic               match, scan_done, have_new, have_tail;
  logic [SLOT_AW-1:0] miss_slot;
  logic [7:0]         rel_cnt;
  logic [31:0]        mul_blk;
  logic [35:0]        prod;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  assign match = chk_valid && slot_tagged[chk_idx] &&
                 (meta_rd.dev == op_dev) && (meta_rd.blk == op_blk);
  assign scan_done = !chk_valid && (scan_idx == LINK_W'(NUM_SLOTS));
  assign have_new  = (handed < LINK_W'(NUM_SLOTS));
  assign have_tail = (tail != EMPTY);
  assign miss_slot = have_new ? handed[SLOT_AW-1:0] : tail[SLOT_AW-1:0];
  assign rel_cnt   = slot_tagged[s_reg] ? meta_rd.cnt : 8'd0;
  assign mul_blk   = (state == S_REL_CK) ? meta_rd.blk : op_blk;
  assign prod      = 36'(mul_blk) * 36'(spb);

  assign meta_raddr = (state == S_SCAN) ? scan_idx[SLOT_AW-1:0] : s_reg;

  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = s_reg;
    meta_wd    = '{dev: op_dev, blk: op_blk, cnt: cnt_reg};
    case (state)
      S_HIT: meta_we = 1'b1;
      S_MISS: begin
        meta_we    = have_new || have_tail;
        meta_waddr = miss_slot;
        meta_wd    = '{dev: op_dev, blk: op_blk, cnt: 8'd1};
      end
      S_REL_CK: begin
        meta_we = (rel_cnt != 8'd0);
        meta_wd = '{dev: meta_rd.dev, blk: meta_rd.blk, cnt: rel_cnt - 8'd1};
      end
      default: ;
    endcase
  end

  // free-list link writes
  always_comb begin
    prev_we    = 1'b0;
    prev_waddr = s_reg;
    prev_wd    = EMPTY;
    next_we    = 1'b0;
    next_waddr = s_reg;
    next_wd    = head;
    case (state)
      S_UNL_WR: begin
        prev_we    = (next_rd != EMPTY);
        prev_waddr = next_rd[SLOT_AW-1:0];
        prev_wd    = prev_rd;
        next_we    = (prev_rd != EMPTY);
        next_waddr = prev_rd[SLOT_AW-1:0];
        next_wd    = next_rd;
      end
      S_PUSH0: begin
        prev_we = 1'b1;
        next_we = 1'b1;
      end
      S_PUSH1: begin
        prev_we    = (head != EMPTY);
        prev_waddr = head[SLOT_AW-1:0];
        prev_wd    = LINK_W'(s_reg);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      spb         <= 4'd2;
      slot_tagged <= '0;
      on_free     <= '0;
      head        <= EMPTY;
      tail        <= EMPTY;
      handed      <= '0;
      chk_valid   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // the finish step reloads the output register itself
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        spb <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_dev   <= device & DEV_MASK;
            op_blk   <= block_number;
            op_mod   <= modified;
            s_reg    <= SLOT_AW'(slot);
            res_slot <= slot;
            if (operation == OP_GET) begin
              scan_idx  <= '0;
              chk_valid <= 1'b0;
              state     <= S_SCAN;
            end else if (32'(slot) >= NUM_SLOTS) begin
              res_status <= ST_UNREF;
              res_cnt    <= 8'd0;
              res_rd     <= 1'b0;
              res_wr     <= 1'b0;
              res_dev    <= 8'd0;
              res_sec    <= '0;
              state      <= S_FIN;
            end else begin
              state <= S_REL_RD;
            end
          end
        end
        S_SCAN: begin
          // read of slot scan_idx overlaps the compare of chk_idx
          if (scan_idx != LINK_W'(NUM_SLOTS)) begin
            scan_idx  <= scan_idx + 1'b1;
            chk_idx   <= scan_idx[SLOT_AW-1:0];
            chk_valid <= 1'b1;
          end else begin
            chk_valid <= 1'b0;
          end
          if (match) begin
            s_reg   <= chk_idx;
            cnt_reg <= (meta_rd.cnt == 8'hFF) ? 8'hFF : meta_rd.cnt + 8'd1;
            state   <= S_HIT;
          end else if (scan_done) begin
            state <= S_MISS;
          end
        end
        S_HIT: begin
          res_status <= ST_HIT;
          res_slot   <= 6'(s_reg);
          res_cnt    <= cnt_reg;
          res_rd     <= 1'b0;
          res_wr     <= 1'b0;
          res_dev    <= 8'd0;
          res_sec    <= '0;
          state      <= on_free[s_reg] ? S_UNL_RD : S_FIN;
        end
        S_MISS: begin
          res_wr <= 1'b0;
          if (have_new || have_tail) begin
            slot_tagged[miss_slot] <= 1'b1;
            s_reg      <= miss_slot;
            res_status <= ST_MISS;
            res_slot   <= 6'(miss_slot);
            res_rd     <= 1'b1;
            res_dev    <= op_dev;
            res_sec    <= 35'(prod);
            res_cnt    <= 8'd1;
            if (have_new) begin
              handed <= handed + 1'b1;
              state  <= S_FIN;
            end else begin
              state <= S_UNL_RD;
            end
          end else begin
            res_status <= ST_NOBUF;
            res_slot   <= 6'd0;
            res_rd     <= 1'b0;
            res_dev    <= 8'd0;
            res_sec    <= '0;
            res_cnt    <= 8'd0;
            state      <= S_FIN;
          end
        end
        S_UNL_RD: state <= S_UNL_WR;
        S_UNL_WR: begin
          if (prev_rd == EMPTY) begin
            head <= next_rd;
          end
          if (next_rd == EMPTY) begin
            tail <= prev_rd;
          end
          on_free[s_reg] <= 1'b0;
          state <= S_FIN;
        end
        S_REL_RD: state <= S_REL_CK;
        S_REL_CK: begin
          res_rd <= 1'b0;
          if (rel_cnt == 8'd0) begin
            res_status <= ST_UNREF;
            res_cnt    <= 8'd0;
            res_wr     <= 1'b0;
            res_dev    <= 8'd0;
            res_sec    <= '0;
            state      <= S_FIN;
          end else begin
            // dirty never outlives a release: write back exactly when modified
            res_status <= ST_RELEASED;
            res_cnt    <= rel_cnt - 8'd1;
            res_wr     <= op_mod;
            res_dev    <= op_mod ? meta_rd.dev : 8'd0;
            res_sec    <= op_mod ? 35'(prod) : 35'd0;
            state      <= (rel_cnt == 8'd1 && !on_free[s_reg]) ? S_PUSH0 : S_FIN;
          end
        end
        S_PUSH0: state <= S_PUSH1;
        S_PUSH1: begin
          head <= LINK_W'(s_reg);
          if (head == EMPTY) begin
            tail <= LINK_W'(s_reg);
          end
          on_free[s_reg] <= 1'b1;
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            status          <= res_status;
            result_slot     <= res_slot;
            read_request    <= res_rd;
            write_request   <= res_wr;
            request_device  <= res_dev;
            request_sector  <= res_sec;
            reference_count <= res_cnt;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/core/bbc_checker.sv
// Port-level checks of the buffer cache directory, bound to the top level.
// Uses bbc_pkg and block_buffer_cache_directory_macros.svh.
`timescale 1ns / 1ps
`include "block_buffer_cache_directory_macros.svh"
module bbc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic        read_request,
  input logic        write_request,
  input logic [7:0]  request_device,
  input logic [34:0] request_sector,
  input logic [7:0]  reference_count
);
  import bbc_pkg::*;

  `BBC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
  `BBC_ASSERT_IMP(a_no_req_zero, out_valid && !read_request && !write_request, request_device == 8'd0 && request_sector == 35'd0)
  `BBC_ASSERT_IMP(a_read_is_miss, out_valid && read_request, status == ST_MISS && reference_count == 8'd1 && !write_request)
  `BBC_ASSERT_IMP(a_write_is_rel, out_valid && write_request, status == ST_RELEASED)
endmodule

bind block_buffer_cache_directory bbc_checker u_bbc_checker (.*);

// File: dv/tb_top.sv
// Self-checking testbench for block_buffer_cache_directory: get/release requests
// against an in-bench directory predictor. Depends on bbc_pkg and the block RTL.
`timescale 1ns / 1ps
module tb_top;
  import bbc_pkg::*;

  typedef struct packed {
    logic        op;
    logic [7:0]  dev;
    logic [31:0] blk;
    logic [5:0]  sl;
    logic        modf;
  } req_t;

  typedef struct packed {
    logic [2:0]  st;
    logic [5:0]  rslot;
    logic        rd;
    logic        wr;
    logic [7:0]  rdev;
    logic [34:0] rsec;
    logic [7:0]  cnt;
  } resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic operation = 1'b0;
  logic [7:0] device = '0;
  logic [31:0] block_number = '0;
  logic [5:0] slot = '0;
  logic modified = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] status;
  logic [5:0] result_slot;
  logic read_request, write_request;
  logic [7:0] request_device;
  logic [34:0] request_sector;
  logic [7:0] reference_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_data = '0;

  block_buffer_cache_directory u_top (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [3:0]  spb;
  logic [7:0]  m_dev [NUM_SLOTS];
  logic [31:0] m_blk [NUM_SLOTS];
  logic        m_tag [NUM_SLOTS];
  logic        m_dirty [NUM_SLOTS];
  logic [7:0]  m_cnt [NUM_SLOTS];
  logic        m_free [NUM_SLOTS];
  int          m_prev [NUM_SLOTS];
  int          m_next [NUM_SLOTS];
  int          f_head, f_tail, handed;

  req_t  pending_reqs[$];
  resp_t expected_resps[$];
  req_t  recent_gets[$];
  int    errors = 0, n_checked = 0, n_sent = 0;
  bit    no_idle = 0, hold_out = 0;
  int    in_gap = 0, out_gap = 0;

  task automatic dir_reset();
    spb = 4'd2;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      m_tag[i] = 0; m_dirty[i] = 0; m_cnt[i] = 0; m_free[i] = 0;
    end
    f_head = NUM_SLOTS; f_tail = NUM_SLOTS; handed = 0;
  endtask

  task automatic unlink(int s);
    int p, n;
    p = m_prev[s]; n = m_next[s];
    if (p == NUM_SLOTS) f_head = n; else m_next[p] = n;
    if (n == NUM_SLOTS) f_tail = p; else m_prev[n] = p;
    m_free[s] = 0;
  endtask

  function automatic logic [34:0] sector_of(logic [31:0] b);
    return 35'({32'd0, b} * {60'd0, spb});
  endfunction

  task automatic predict_request(req_t r);
    resp_t e;
    int s;
    logic [7:0] d;
    e = '0;
    d = r.dev & DEV_MASK;
    if (r.op == OP_GET) begin
      s = NUM_SLOTS;
      for (int i = NUM_SLOTS - 1; i >= 0; i--)
        if (m_tag[i] && m_dev[i] == d && m_blk[i] == r.blk) s = i;
      if (s < NUM_SLOTS) begin
        if (m_cnt[s] != 8'd255) m_cnt[s]++;
        if (m_free[s]) unlink(s);
        e.st = ST_HIT; e.rslot = 6'(s); e.cnt = m_cnt[s];
      end else begin
        if (handed < NUM_SLOTS) begin
          s = handed; handed++;
        end else if (f_tail != NUM_SLOTS) begin
          s = f_tail; unlink(s);
        end
        if (s == NUM_SLOTS) begin
          e.st = ST_NOBUF;
        end else begin
          m_tag[s] = 1; m_dev[s] = d; m_blk[s] = r.blk; m_dirty[s] = 0; m_cnt[s] = 1;
          e.st = ST_MISS; e.rslot = 6'(s); e.rd = 1; e.rdev = d;
          e.rsec = sector_of(r.blk); e.cnt = 1;
        end
      end
    end else begin
      s = r.sl;
      e.rslot = r.sl;
      if (m_cnt[s] == 0) begin
        e.st = ST_UNREF;
      end else begin
        m_cnt[s]--;
        if (r.modf) m_dirty[s] = 1;
        if (m_dirty[s]) begin
          e.wr = 1; e.rdev = m_dev[s]; e.rsec = sector_of(m_blk[s]); m_dirty[s] = 0;
        end
        if (m_cnt[s] == 0 && !m_free[s]) begin
          m_prev[s] = NUM_SLOTS; m_next[s] = f_head;
          if (f_head == NUM_SLOTS) f_tail = s; else m_prev[f_head] = s;
          f_head = s; m_free[s] = 1;
        end
        e.st = ST_RELEASED; e.cnt = m_cnt[s];
      end
    end
    expected_resps.push_back(e);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want, n_checked);
    errors++;
  endtask

  // driver: prediction happens at acceptance
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_request(pending_reqs.pop_front());
        n_sent++;
      end
      if (in_valid && in_stall) begin
        // hold payload
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > (in_valid && !in_stall ? 0 : 0)
                   && !(in_valid && !in_stall && pending_reqs.size() == 0)) begin
        if (pending_reqs.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 9) == 0) begin
          in_gap <= $urandom_range(0, 4);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          operation <= pending_reqs[0].op;
          device <= pending_reqs[0].dev;
          block_number <= pending_reqs[0].blk;
          slot <= pending_reqs[0].sl;
          modified <= pending_reqs[0].modf;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_resps.size() == 0) begin
          report_mismatch("unexpected result", {61'd0, status}, 64'd0);
        end else begin
          resp_t e;
          e = expected_resps.pop_front();
          if (status !== e.st) report_mismatch("status", status, e.st);
          if (result_slot !== e.rslot) report_mismatch("result_slot", result_slot, e.rslot);
          if (read_request !== e.rd) report_mismatch("read_request", read_request, e.rd);
          if (write_request !== e.wr) report_mismatch("write_request", write_request, e.wr);
          if (request_device !== e.rdev)
            report_mismatch("request_device", request_device, e.rdev);
          if (request_sector !== e.rsec)
            report_mismatch("request_sector", request_sector, e.rsec);
          if (reference_count !== e.cnt)
            report_mismatch("reference_count", reference_count, e.cnt);
        end
        n_checked++;
      end
      if (hold_out) out_stall <= 1'b1;
      else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  function automatic req_t mk_get(logic [7:0] d, logic [31:0] b);
    req_t r;
    r = '0; r.op = OP_GET; r.dev = d; r.blk = b; r.sl = 6'($urandom);
    r.modf = 1'($urandom);
    return r;
  endfunction

  function automatic req_t mk_rel(logic [5:0] s, logic m);
    req_t r;
    r.op = OP_RELEASE; r.dev = 8'($urandom); r.blk = $urandom; r.sl = s; r.modf = m;
    return r;
  endfunction

  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_resps.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_cfg(logic [3:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1; cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    spb = v;
  endtask

  // random item: a get built from recently used devices and blocks to make hits common, else a release or a random get
  function automatic req_t rand_item();
    int k;
    k = $urandom_range(0, 99);
    if (k < 45 && recent_gets.size() > 0)
      return mk_get(recent_gets[$urandom_range(0, recent_gets.size() - 1)].dev,
                    recent_gets[$urandom_range(0, recent_gets.size() - 1)].blk);
    if (k < 70) return mk_rel(6'($urandom), $urandom_range(0, 3) == 0);
    return mk_get(8'($urandom_range(0, 3)), $urandom_range(0, 5) == 0 ? $urandom
                  : $urandom_range(0, 40));
  endfunction

  initial begin
    req_t r;
    logic [3:0] spb_set [6] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd2};
    dir_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // directed
    pending_reqs.push_back(mk_rel(6'd0, 1'b0));           // release never-used
    pending_reqs.push_back(mk_get(8'hFF, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk_get(8'hFF, 32'hFFFF_FFFF)); // hit
    pending_reqs.push_back(mk_get(8'h00, 32'h0));
    pending_reqs.push_back(mk_rel(6'd0, 1'b1));           // dirty write back
    pending_reqs.push_back(mk_rel(6'd0, 1'b0));
    pending_reqs.push_back(mk_rel(6'd0, 1'b0));           // count already zero
    pending_reqs.push_back(mk_rel(6'd63, 1'b1));
    pending_reqs.push_back(mk_get(8'hA5, 32'h8000_0000));
    pending_reqs.push_back(mk_rel(6'd1, 1'b1));
    pending_reqs.push_back(mk_get(8'h00, 32'h0));         // hit on free slot
    drain();
    // saturate slot 2's count: 260 hits
    for (int i = 0; i < 260; i++) pending_reqs.push_back(mk_get(8'hA5, 32'h8000_0000));
    drain();
    // fill all slots, then no free buffer, then LRU reuse
    for (int i = 0; i < 64; i++) pending_reqs.push_back(mk_get(8'h11, i + 100));
    pending_reqs.push_back(mk_get(8'h22, 32'd7));
    for (int i = 10; i < 20; i++) pending_reqs.push_back(mk_rel(6'(i), i[0]));
    pending_reqs.push_back(mk_get(8'h22, 32'd8));
    // long receiver hold-off while sender keeps offering
    hold_out = 1;
    for (int i = 0; i < 8; i++) pending_reqs.push_back(mk_get(8'h33, i));
    repeat (600) @(posedge clk);
    hold_out = 0;
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(spb_set[ph]);
      if (ph == 5) no_idle = 1;
      for (int i = 0; i < 130; i++) begin
        r = rand_item();
        if (r.op == OP_GET) begin
          recent_gets.push_back(r);
          if (recent_gets.size() > 24) void'(recent_gets.pop_front());
        end
        pending_reqs.push_back(r);
        // keep free slots available: release a random slot now and then
        if ($urandom_range(0, 2) == 0) pending_reqs.push_back(mk_rel(6'($urandom), 1'b0));
      end
      drain();
    end
    $display("Covered %0d requests, %0d results checked, six sector scalings.", n_sent, n_checked);
    $display("Included saturation, full directory, LRU reuse and long output hold-off.");
    if (errors == 0 && expected_resps.size() == 0) begin
      $display("block_buffer_cache_directory test passed");
    end else begin
      $display("block_buffer_cache_directory test failed");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("block_buffer_cache_directory test failed");
    $finish;
  end
endmodule
